// File: rtl/odometry_pose_interpolator_assert.svh
// Assertion macros used by the interpolator top level.
`ifndef ODOMETRY_POSE_INTERPOLATOR_ASSERT_SVH
`define ODOMETRY_POSE_INTERPOLATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define OPI_ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define OPI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// File: rtl/opi_pkg.sv
// Types, constants and tables of the odometry pose interpolator.
`timescale 1ns / 1ps
package opi_pkg;

  localparam int DivSteps = 49;
  localparam int MulSteps = 9;
  localparam logic signed [28:0] AngPi     = 29'sd52707179;
  localparam logic signed [28:0] AngHalfPi = 29'sd26353589;
  localparam logic signed [17:0] YawLimit  = 18'sd25736;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_DIV_INIT, OP_DIV_STEP, OP_ROT_INIT0, OP_ROT_INIT1,
    OP_ROT_STEP, OP_ROT_SAVE0, OP_ROT_SAVE1, OP_MUL, OP_VEC_INIT, OP_VEC_STEP,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [5:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic need;
  } dp_stat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_INIT, S_DIV, S_ROT0_INIT, S_ROT0, S_ROT0_SAVE, S_ROT1_INIT,
    S_ROT1, S_ROT1_SAVE, S_MUL, S_VEC_INIT, S_VEC, S_OUT
  } ctrl_state_t;

  // Arctangent of 2^-i, radians at scale 2^24.
  function automatic logic [23:0] atan_entry(input logic [4:0] i);
    logic [23:0] r;
    unique case (i)
      5'd0: r = 24'd13176795;
      5'd1: r = 24'd7778716;
      5'd2: r = 24'd4110060;
      5'd3: r = 24'd2086331;
      5'd4: r = 24'd1047214;
      5'd5: r = 24'd524117;
      5'd6: r = 24'd262123;
      5'd7: r = 24'd131069;
      5'd8: r = 24'd65536;
      5'd9: r = 24'd32768;
      5'd10: r = 24'd16384;
      5'd11: r = 24'd8192;
      5'd12: r = 24'd4096;
      5'd13: r = 24'd2048;
      5'd14: r = 24'd1024;
      5'd15: r = 24'd512;
      5'd16: r = 24'd256;
      5'd17: r = 24'd128;
      5'd18: r = 24'd64;
      5'd19: r = 24'd32;
      5'd20: r = 24'd16;
      5'd21: r = 24'd8;
      5'd22: r = 24'd4;
      5'd23: r = 24'd2;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/opi_sensor_if.sv
// Input channel carrying one sensor read per transfer.
`timescale 1ns / 1ps
interface opi_sensor_if;
  logic               valid;
  logic               ready;
  logic        [31:0] event_time;
  logic               laser_fresh;
  logic               odometry_fresh;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_yaw;

  modport source (output valid, event_time, laser_fresh, odometry_fresh, pose_x, pose_y,
                  pose_yaw, input ready);
  modport sink (input valid, event_time, laser_fresh, odometry_fresh, pose_x, pose_y,
                pose_yaw, output ready);
endinterface

// File: rtl/opi_result_if.sv
// Output channel carrying one interpolated pose per transfer.
`timescale 1ns / 1ps
interface opi_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] interp_x;
  logic signed [31:0] interp_y;
  logic signed [15:0] interp_yaw;
  logic        [16:0] after_weight;
  logic        [31:0] scan_time;

  modport source (output valid, interp_x, interp_y, interp_yaw, after_weight, scan_time,
                  input ready);
  modport sink (input valid, interp_x, interp_y, interp_yaw, after_weight, scan_time,
                output ready);
endinterface

// File: rtl/opi_ctrl.sv
// Sequencer that steps the datapath through division, CORDIC and blend passes.
`timescale 1ns / 1ps
module opi_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  opi_pkg::dp_stat_t stat,
  output opi_pkg::dp_cmd_t  cmd
);
  import opi_pkg::*;

  localparam logic [5:0] DivLast = 6'(DivSteps - 1);
  localparam logic [5:0] MulLast = 6'(MulSteps - 1);
  localparam logic [5:0] CorLast = 6'(CORDIC_STEPS - 1);

  ctrl_state_t state, state_next;
  logic [5:0]  cnt, cnt_next;
  logic        load;

  // State, counter and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cnt_next   = '0;
    cmd.op     = OP_NONE;
    cmd.idx    = cnt;
    in_ready   = 1'b0;
    load       = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          if (stat.need) begin
            state_next = S_DIV_INIT;
          end
        end
      end
      S_DIV_INIT: begin
        cmd.op     = OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == DivLast) begin
          state_next = S_ROT0_INIT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_ROT0_INIT: begin
        cmd.op     = OP_ROT_INIT0;
        state_next = S_ROT0;
      end
      S_ROT0: begin
        cmd.op = OP_ROT_STEP;
        if (cnt == CorLast) begin
          state_next = S_ROT0_SAVE;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_ROT0_SAVE: begin
        cmd.op     = OP_ROT_SAVE0;
        state_next = S_ROT1_INIT;
      end
      S_ROT1_INIT: begin
        cmd.op     = OP_ROT_INIT1;
        state_next = S_ROT1;
      end
      S_ROT1: begin
        cmd.op = OP_ROT_STEP;
        if (cnt == CorLast) begin
          state_next = S_ROT1_SAVE;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_ROT1_SAVE: begin
        cmd.op     = OP_ROT_SAVE1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (cnt == MulLast) begin
          state_next = S_VEC_INIT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_VEC_INIT: begin
        cmd.op     = OP_VEC_INIT;
        state_next = S_VEC;
      end
      S_VEC: begin
        cmd.op = OP_VEC_STEP;
        if (cnt == CorLast) begin
          state_next = S_OUT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_LOAD_OUT;
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// File: rtl/opi_dp.sv
// Datapath: pose history, weight divider, shared CORDIC and blend multiplier.
`timescale 1ns / 1ps
module opi_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic         [31:0] event_time,
  input  logic                laser_fresh,
  input  logic                odometry_fresh,
  input  logic signed  [31:0] pose_x,
  input  logic signed  [31:0] pose_y,
  input  logic signed  [15:0] pose_yaw,
  input  opi_pkg::dp_cmd_t    cmd,
  output opi_pkg::dp_stat_t   stat,
  output logic signed  [31:0] interp_x,
  output logic signed  [31:0] interp_y,
  output logic signed  [15:0] interp_yaw,
  output logic         [16:0] after_weight,
  output logic         [31:0] scan_time
);
  import opi_pkg::*;

  logic               running, scan_seen;
  logic        [31:0] last_scan_time, older_time, newer_time;
  logic signed [31:0] older_x, older_y, newer_x, newer_y;
  logic signed [15:0] older_yaw, newer_yaw;

  logic        [31:0] dvs, rem;
  logic        [48:0] dvd;
  logic               dt_zero;
  logic        [16:0] wt;

  logic signed [52:0] cx, cy;
  logic signed [28:0] cz;
  logic               flip, vec_zero;
  logic signed [33:0] c0, s0, c1, s1;

  logic signed [51:0] prod;
  logic signed [52:0] acc, bx, by, sxs, sys;

  logic        [31:0] scan_n, dt_w, num_w;
  logic        [32:0] trial;
  logic signed [15:0] yaw_sel;
  logic signed [28:0] z_raw;
  logic               dir;
  logic signed [52:0] xs, ys;
  logic signed [28:0] tab;
  logic        [3:0]  k, j;
  logic signed [33:0] mv;
  logic signed [17:0] mw;
  logic signed [52:0] negx, negy;
  logic signed [52:0] rx, ry;
  logic signed [28:0] zr;
  logic signed [17:0] q;

  // A transfer yields a result when the scan lies inside the new odometry interval.
  always_comb begin
    scan_n    = laser_fresh ? event_time : last_scan_time;
    stat.need = running && odometry_fresh && (scan_seen || laser_fresh) &&
                (newer_time <= scan_n) && (scan_n <= event_time);
  end

  // Combinational helpers for the divider, CORDIC and multiplier steps.
  always_comb begin
    dt_w    = newer_time - older_time;
    num_w   = last_scan_time - older_time;
    trial   = {rem, dvd[48]};
    yaw_sel = (cmd.op == OP_ROT_INIT0) ? older_yaw : newer_yaw;
    z_raw   = {{2{yaw_sel[15]}}, yaw_sel, 11'b0};
    dir     = (cmd.op == OP_VEC_STEP) ? cy[52] : !cz[28];
    xs      = cx >>> cmd.idx[4:0];
    ys      = cy >>> cmd.idx[4:0];
    tab     = 29'(atan_entry(cmd.idx[4:0]));
    k       = cmd.idx[3:0];
    j       = k - 4'd1;
    negx    = -cx;
    negy    = -cy;
    case (k[2:0])
      3'd0: mv = 34'(older_x);
      3'd1: mv = 34'(newer_x);
      3'd2: mv = 34'(older_y);
      3'd3: mv = 34'(newer_y);
      3'd4: mv = c0;
      3'd5: mv = c1;
      3'd6: mv = s0;
      default: mv = s1;
    endcase
    mw = k[0] ? $signed({1'b0, wt}) : $signed({1'b0, 17'd65536 - wt});
    rx = bx + 53'sd32768;
    ry = by + 53'sd32768;
    zr = cz + 29'sd1024;
    q  = 18'(zr >>> 11);
  end

  // Pose history and all working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      scan_seen <= 1'b0;
    end else begin
      case (cmd.op)
        OP_ACCEPT: begin
          if (!running) begin
            if (laser_fresh && odometry_fresh) begin
              running    <= 1'b1;
              older_time <= event_time;
              newer_time <= event_time;
              older_x    <= pose_x;
              older_y    <= pose_y;
              older_yaw  <= pose_yaw;
              newer_x    <= pose_x;
              newer_y    <= pose_y;
              newer_yaw  <= pose_yaw;
            end
          end else begin
            if (laser_fresh) begin
              last_scan_time <= event_time;
              scan_seen      <= 1'b1;
            end
            if (odometry_fresh) begin
              older_time <= newer_time;
              older_x    <= newer_x;
              older_y    <= newer_y;
              older_yaw  <= newer_yaw;
              newer_time <= event_time;
              newer_x    <= pose_x;
              newer_y    <= pose_y;
              newer_yaw  <= pose_yaw;
            end
          end
        end
        OP_DIV_INIT: begin
          dvs     <= dt_w;
          dt_zero <= (dt_w == 32'd0);
          rem     <= '0;
          dvd     <= {1'b0, num_w, 16'b0} + 49'(dt_w >> 1);
        end
        OP_DIV_STEP: begin
          if (trial >= {1'b0, dvs}) begin
            rem <= 32'(trial - {1'b0, dvs});
            dvd <= {dvd[47:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            dvd <= {dvd[47:0], 1'b0};
          end
        end
        OP_ROT_INIT0, OP_ROT_INIT1: begin
          if (cmd.op == OP_ROT_INIT0) begin
            wt <= dt_zero ? 17'd65536 : dvd[16:0];
          end
          // Fold the heading into the convergence range of the CORDIC.
          if (z_raw > AngHalfPi) begin
            cz   <= z_raw - AngPi;
            flip <= 1'b1;
          end else if (z_raw < -AngHalfPi) begin
            cz   <= z_raw + AngPi;
            flip <= 1'b1;
          end else begin
            cz   <= z_raw;
            flip <= 1'b0;
          end
          cx <= 53'sd1073741824;
          cy <= '0;
        end
        OP_ROT_STEP, OP_VEC_STEP: begin
          if (dir) begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - tab;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + tab;
          end
        end
        OP_ROT_SAVE0: begin
          c0 <= flip ? negx[33:0] : cx[33:0];
          s0 <= flip ? negy[33:0] : cy[33:0];
        end
        OP_ROT_SAVE1: begin
          c1 <= flip ? negx[33:0] : cx[33:0];
          s1 <= flip ? negy[33:0] : cy[33:0];
        end
        OP_MUL: begin
          // One product per cycle, summed in pairs in the following cycle.
          prod <= mw * mv;
          if (k != 4'd0) begin
            if (!j[0]) begin
              acc <= 53'(prod);
            end else begin
              case (j[2:1])
                2'd0: bx <= acc + 53'(prod);
                2'd1: by <= acc + 53'(prod);
                2'd2: sxs <= acc + 53'(prod);
                default: sys <= acc + 53'(prod);
              endcase
            end
          end
        end
        OP_VEC_INIT: begin
          vec_zero <= (sxs == 53'sd0) && (sys == 53'sd0);
          if (sxs < 53'sd0) begin
            cz <= (sys >= 53'sd0) ? AngPi : -AngPi;
            cx <= -sxs;
            cy <= -sys;
          end else begin
            cz <= '0;
            cx <= sxs;
            cy <= sys;
          end
        end
        OP_LOAD_OUT: begin
          interp_x     <= 32'(rx >>> 16);
          interp_y     <= 32'(ry >>> 16);
          after_weight <= wt;
          scan_time    <= last_scan_time;
          if (vec_zero) begin
            interp_yaw <= '0;
          end else if (q > YawLimit) begin
            interp_yaw <= 16'(YawLimit);
          end else if (q < -YawLimit) begin
            interp_yaw <= 16'(-YawLimit);
          end else begin
            interp_yaw <= q[15:0];
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/odometry_pose_interpolator.sv
// Top level of the odometry pose interpolator.
`timescale 1ns / 1ps
`include "odometry_pose_interpolator_assert.svh"
// Takes one sensor read per transfer and, when an odometry update brackets the
// latest laser scan time, returns the pose interpolated at that time. A read
// that yields no result leaves the block ready for the next read. A read that
// yields a result keeps the block busy through a bit-serial divider for the
// weight, two CORDIC rotation passes for the unit vectors of both headings, one
// shared multiplier for the blends and a vectoring CORDIC pass for the mean
// heading. The finished result sits in an output register, so the next read is
// taken while it waits.
module odometry_pose_interpolator #(
  parameter int CORDIC_STEPS = 16
) (
  input logic         clk,
  input logic         rst,
  opi_sensor_if.sink  sensor,
  opi_result_if.source result
);
  import opi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  opi_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sensor.valid),
    .in_ready  (sensor.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  opi_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .event_time     (sensor.event_time),
    .laser_fresh    (sensor.laser_fresh),
    .odometry_fresh (sensor.odometry_fresh),
    .pose_x         (sensor.pose_x),
    .pose_y         (sensor.pose_y),
    .pose_yaw       (sensor.pose_yaw),
    .cmd            (cmd),
    .stat           (stat),
    .interp_x       (result.interp_x),
    .interp_y       (result.interp_y),
    .interp_yaw     (result.interp_yaw),
    .after_weight   (result.after_weight),
    .scan_time      (result.scan_time)
  );

  // A loaded result is presented on the next cycle.
  `OPI_ASSERT_NEXT(a_load_shows, cmd.op == OP_LOAD_OUT, result.valid, "result not shown")
  // A transfer without a result leaves the block ready again.
  `OPI_ASSERT_NEXT(a_no_result_ready, sensor.valid && sensor.ready && !stat.need,
                   sensor.ready, "idle transfer left block busy")
  // The weight never exceeds one.
  `OPI_ASSERT_IMPL(a_weight_range, result.valid, result.after_weight <= 17'd65536,
                   "weight above one")
endmodule

// File: test/opi_pose_checker.sv
// Checker that predicts interpolated poses and compares them with the block's results.
`timescale 1ns / 1ps
module opi_pose_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  opi_sensor_if.sink  sensor,
  opi_result_if.sink  result,
  output int          fail_count,
  output int          pending_poses
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] yaw;
    logic        [16:0] weight;
    logic        [31:0] scan;
  } pose_t;

  pose_t expected_poses[$];

  // Tracker state of the interpolator.
  bit                 is_running;
  bit                 have_scan;
  logic        [31:0] scan_stamp;
  logic        [31:0] t_old;
  logic        [31:0] t_new;
  logic signed [31:0] x_old;
  logic signed [31:0] y_old;
  logic signed [15:0] yaw_old;
  logic signed [31:0] x_new;
  logic signed [31:0] y_new;
  logic signed [15:0] yaw_new;

  int table_steps[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                          131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                          128, 64, 32, 16, 8, 4, 2};

  function automatic int step_count();
    return (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  endfunction

  // Rotation pass giving the scaled unit vector of a heading.
  function automatic void heading_vector(input logic signed [15:0] hd,
                                         output longint c, output longint s);
    longint z;
    longint cx;
    longint cy;
    longint nx;
    bit     flip;
    z = longint'(hd) * 2048;
    cx = 64'sd1 << 30;
    cy = 0;
    flip = 0;
    if (z > 26353589) begin
      z -= 52707179;
      flip = 1;
    end else if (z < -26353589) begin
      z += 52707179;
      flip = 1;
    end
    for (int i = 0; i < step_count(); i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        z -= table_steps[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z += table_steps[i];
      end
      cx = nx;
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
  endfunction

  // Vectoring pass giving the heading of a summed vector in Q3.13.
  function automatic longint mean_heading(input longint vx, input longint vy);
    longint z;
    longint nx;
    longint q;
    z = 0;
    if (vx == 0 && vy == 0) return 0;
    if (vx < 0) begin
      z = (vy >= 0) ? 52707179 : -52707179;
      vx = -vx;
      vy = -vy;
    end
    for (int i = 0; i < step_count(); i++) begin
      if (vy < 0) begin
        nx = vx - (vy >>> i);
        vy = vy + (vx >>> i);
        z -= table_steps[i];
      end else begin
        nx = vx + (vy >>> i);
        vy = vy - (vx >>> i);
        z += table_steps[i];
      end
      vx = nx;
    end
    q = (z + 1024) >>> 11;
    if (q > 25736) q = 25736;
    if (q < -25736) q = -25736;
    return q;
  endfunction

  function automatic logic signed [31:0] mix(input longint w, input logic signed [31:0] p0,
                                             input logic signed [31:0] p1);
    longint acc;
    acc = (65536 - w) * longint'(p0) + w * longint'(p1) + 32768;
    return 32'(acc >>> 16);
  endfunction

  // Updates the tracker with one sensor read and queues any resulting pose.
  task automatic track_read(input logic [31:0] t, input bit lf, input bit odo,
                            input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [15:0] pw);
    logic [31:0] dt;
    logic [31:0] num;
    longint      w;
    longint      c0, s0, c1, s1;
    pose_t       p;
    if (!is_running) begin
      if (lf && odo) begin
        t_old = t; t_new = t;
        x_old = px; y_old = py; yaw_old = pw;
        x_new = px; y_new = py; yaw_new = pw;
        is_running = 1;
      end
      return;
    end
    if (lf) begin
      scan_stamp = t;
      have_scan = 1;
    end
    if (!odo) return;
    t_old = t_new; x_old = x_new; y_old = y_new; yaw_old = yaw_new;
    t_new = t; x_new = px; y_new = py; yaw_new = pw;
    if (!have_scan || t_old > scan_stamp || scan_stamp > t_new) return;
    dt = t_new - t_old;
    num = scan_stamp - t_old;
    if (dt == 0) w = 65536;
    else w = longint'(((64'(num) << 16) + 64'(dt / 2)) / 64'(dt));
    heading_vector(yaw_old, c0, s0);
    heading_vector(yaw_new, c1, s1);
    p.yaw = 16'(mean_heading((65536 - w) * c0 + w * c1, (65536 - w) * s0 + w * s1));
    p.x = mix(w, x_old, x_new);
    p.y = mix(w, y_old, y_new);
    p.weight = 17'(w);
    p.scan = scan_stamp;
    expected_poses.push_back(p);
  endtask

  assign pending_poses = expected_poses.size();

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      fail_count = 0;
      have_scan = 0;
      is_running = 0;
      scan_stamp = 0;
      t_old = 0; t_new = 0;
      x_old = 0; y_old = 0; yaw_old = 0;
      x_new = 0; y_new = 0; yaw_new = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_poses.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          e = expected_poses.pop_front();
          if (result.interp_x !== e.x || result.interp_y !== e.y ||
              result.interp_yaw !== e.yaw || result.after_weight !== e.weight ||
              result.scan_time !== e.scan) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp x=%0d y=%0d yaw=%0d w=%0d t=%0d got x=%0d y=%0d yaw=%0d w=%0d t=%0d",
                       e.x, e.y, e.yaw, e.weight, e.scan, result.interp_x, result.interp_y,
                       result.interp_yaw, result.after_weight, result.scan_time);
          end
        end
      end
      if (sensor.valid && sensor.ready)
        track_read(sensor.event_time, sensor.laser_fresh, sensor.odometry_fresh,
                   sensor.pose_x, sensor.pose_y, sensor.pose_yaw);
    end
  end

endmodule

// File: test/tb_odometry_pose_interpolator.sv
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module tb_odometry_pose_interpolator;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_poses;
  bit   long_hold;

  opi_sensor_if sensor();
  opi_result_if result();

  odometry_pose_interpolator i_dut (
    .clk    (clk),
    .rst    (rst),
    .sensor (sensor.sink),
    .result (result.source)
  );

  opi_pose_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .sensor        (sensor.sink),
    .result        (result.sink),
    .fail_count    (fail_count),
    .pending_poses (pending_poses)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  logic [31:0] clock_ms;
  int          gap_left;
  int          burst_left;

  // Offers one read and holds it until the transfer happens. Valid drops only
  // during the gap between bursts.
  task automatic send_read(input logic [31:0] t, input bit lf, input bit odo,
                           input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] pw);
    if (burst_left == 0) begin
      if (gap_left != 0) sensor.valid <= 1'b0;
      repeat (gap_left) @(negedge clk);
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
    end
    burst_left--;
    sensor.valid <= 1'b1;
    sensor.event_time <= t;
    sensor.laser_fresh <= lf;
    sensor.odometry_fresh <= odo;
    sensor.pose_x <= px;
    sensor.pose_y <= py;
    sensor.pose_yaw <= pw;
    @(posedge clk);
    while (!sensor.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_yaw();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  // Well-formed sequence: odometry update, scan, then an odometry update that brackets it.
  task automatic send_sequence();
    logic [31:0] px, py;
    px = $urandom;
    py = $urandom;
    send_read(clock_ms, 0, 1, px, py, rand_yaw());
    clock_ms += $urandom_range(0, 40);
    send_read(clock_ms, 1, ($urandom_range(0, 5) == 0), $urandom, $urandom, rand_yaw());
    clock_ms += $urandom_range(0, 60);
    send_read(clock_ms, $urandom_range(0, 1), 1, px + $urandom_range(0, 9999),
              py - $urandom_range(0, 9999), rand_yaw());
  endtask

  // Receiver: random stall pattern, plus one long hold-off.
  initial begin
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        result.ready <= 1'b0;
        repeat (2000) @(negedge clk);
        long_hold = 0;
      end
      result.ready <= ($urandom_range(0, 2) != 0) || ($urandom_range(0, 7) == 0);
      @(negedge clk);
    end
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    sensor.valid = 1'b0;
    sensor.event_time = '0;
    sensor.laser_fresh = 1'b0;
    sensor.odometry_fresh = 1'b0;
    sensor.pose_x = '0;
    sensor.pose_y = '0;
    sensor.pose_yaw = '0;
    long_hold = 0;
    gap_left = 0;
    burst_left = 20;
    clock_ms = 1000;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: ignored init reads, seeding read, extremes and special cases.
    send_read(5, 1, 0, 32'h7FFFFFFF, 0, 0);
    send_read(6, 0, 1, 0, 0, 0);
    send_read(100, 1, 1, 32'h80000000, 32'h7FFFFFFF, 16'sd25736);
    send_read(100, 1, 0, 0, 0, 0);
    send_read(100, 0, 1, 32'h7FFFFFFF, 32'h80000000, -16'sd25736);
    send_read(150, 1, 0, 0, 0, 0);
    send_read(200, 0, 1, 32'hFFFFFFFF, 0, 16'sh7FFF);
    send_read(300, 0, 1, 0, 32'hFFFFFFFF, 16'sh8000);
    send_read(250, 1, 1, 12345, -6789, 16'sd12868);
    send_read(400, 0, 1, 0, 0, -16'sd12868);
    send_read(300, 1, 0, 0, 0, 0);
    send_read(300, 0, 1, 1 << 16, 2 << 16, 0);
    send_read(500, 1, 0, 0, 0, 0);
    send_read(600, 0, 1, 3 << 16, 0, 16'sd25736);
    send_read(32'hFFFFFFFF, 1, 0, 0, 0, 0);
    send_read(32'hFFFFFFFF, 0, 1, 32'h55555555, 32'hAAAAAAAA, 16'h5555);
    send_read(32'hFFFFFFFF, 0, 1, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA);
    send_read(0, 1, 1, 0, 0, 0);

    // Random: mostly bracketing sequences, some noise.
    for (int n = 0; n < 130; n++) begin
      if (n == 40) long_hold = 1;
      if ($urandom_range(0, 4) == 0)
        send_read($urandom, $urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom,
                  16'($urandom));
      else
        send_sequence();
      if ($urandom_range(0, 9) == 0) clock_ms = $urandom_range(0, 32'hFFFF0000);
    end
    sensor.valid <= 1'b0;

    while (pending_poses != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
